>>> rtl/assert_macros.svh
// Assertion helpers shared by the allocator RTL.
// Both expect clk_i in the enclosing module; BPFA_ASSERT also expects rst_ni.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked while out of reset.
`define BPFA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked on every edge, reset included.
`define BPFA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

>>> rtl/bpfa_pkg.sv
// ----------------------------------------------------------------------------
// bpfa_pkg
// Shared types and constants of the bitmap page frame allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package bpfa_pkg;

  localparam int unsigned PAGE_W     = 16;
  localparam int unsigned CNT_W      = 17;
  localparam int unsigned PTR_W      = 18;
  localparam int unsigned WORD_BITS  = 64;
  localparam int unsigned BIT_W      = 6;
  localparam int unsigned MAP_WORDS  = 1024;
  localparam int unsigned WADDR_W    = 10;
  localparam int unsigned STEP_PAGES = 8;
  localparam int unsigned STEP_W     = 4;
  localparam int unsigned APB_ADDR_W = 3;
  localparam int unsigned APB_DATA_W = 32;

  localparam logic [CNT_W-1:0] PAGE_SPAN = 17'h10000;

  // request modes
  localparam logic [2:0] MODE_ALLOC     = 3'd0;
  localparam logic [2:0] MODE_ALLOC_DMA = 3'd1;
  localparam logic [2:0] MODE_FREE      = 3'd2;
  localparam logic [2:0] MODE_MARK_FREE = 3'd3;
  localparam logic [2:0] MODE_RESERVE   = 3'd4;

  // register select (paddr bit 2)
  localparam logic REG_TOTAL_PAGES = 1'b0;
  localparam logic REG_DMA_LIMIT   = 1'b1;

  typedef enum logic [2:0] {
    ST_OK     = 3'd0,
    ST_ZERO   = 3'd1,
    ST_NORUN  = 3'd2,
    ST_DOUBLE = 3'd3,
    ST_RANGE  = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_SCAN,
    OP_FREE,
    OP_SETFREE,
    OP_RESERVE
  } op_e;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_CHECK,
    S_READ,
    S_LOAD,
    S_PROC,
    S_WRITE,
    S_WRITE_END,
    S_MARK,
    S_DONE
  } state_e;

  typedef struct packed {
    logic accept;
    logic clr;
    logic rd;
    logic load;
    logic proc;
    logic wr;
    logic mark;
  } cmd_t;

  typedef struct packed {
    logic empty;
    logic found;
    logic stop;
    logic walk_end;
    logic word_end;
    logic writes;
    logic clr_last;
  } stat_t;

endpackage

`default_nettype wire

>>> rtl/bpfa_ram.sv
// ----------------------------------------------------------------------------
// bpfa_ram
// Generic single-port RAM, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module bpfa_ram #(
  parameter int unsigned WIDTH  = 64,
  parameter int unsigned DEPTH  = 1024,
  parameter int unsigned ADDR_W = $clog2(DEPTH)
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [ADDR_W-1:0] addr_i,
  input  wire logic [WIDTH-1:0]  wdata_i,
  output logic      [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

`default_nettype wire

>>> rtl/bpfa_datapath.sv
// ----------------------------------------------------------------------------
// bpfa_datapath
// Used map RAM, walk pointers, run tracker and free page counter.
// Handles up to eight pages of the loaded map word per cycle while stepping.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module bpfa_datapath import bpfa_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire cmd_t              cmd_i,
  output stat_t                  stat_o,
  input  wire logic [2:0]        mode_i,
  input  wire logic [PAGE_W-1:0] start_page_i,
  input  wire logic [CNT_W-1:0]  page_count_i,
  input  wire logic [CNT_W-1:0]  total_pages_i,
  input  wire logic [CNT_W-1:0]  dma_limit_i,
  output logic      [2:0]        status_o,
  output logic      [PAGE_W-1:0] found_page_o,
  output logic      [CNT_W-1:0]  free_count_o
);

  op_e                  op_q;
  logic [PTR_W-1:0]     p_q, e_q, p_n;
  logic [CNT_W-1:0]     n_q, lim_q, run_q, run_n, cnt_q;
  logic [PAGE_W-1:0]    base_q, base_n, found_q;
  logic [WORD_BITS-1:0] w_q, w_n, rdata;
  logic [WADDR_W-1:0]   wa_q, clr_q, ram_addr;
  status_e              status_q, status_n;
  logic                 empty_q, found_n, stop_n;
  logic [STEP_W-1:0]    inc, dec;

  // request decode
  logic [CNT_W-1:0] lim_all, lim_sel;
  logic [PTR_W-1:0] end_sum, end_clip;

  always_comb begin
    lim_all  = (total_pages_i > PAGE_SPAN) ? PAGE_SPAN : total_pages_i;
    lim_sel  = (mode_i == MODE_ALLOC_DMA && dma_limit_i < lim_all) ? dma_limit_i : lim_all;
    end_sum  = PTR_W'(start_page_i) + PTR_W'(page_count_i);
    end_clip = (end_sum > PTR_W'(lim_all)) ? PTR_W'(lim_all) : end_sum;
  end

  // one step: up to eight pages, stopping at word end, walk end, a hit or a free error
  always_comb begin
    logic [PTR_W-1:0] q;
    logic [BIT_W-1:0] bi;
    logic             alive;
    w_n      = w_q;
    run_n    = run_q;
    base_n   = base_q;
    p_n      = p_q;
    status_n = status_q;
    inc      = '0;
    dec      = '0;
    alive    = 1'b1;
    found_n  = 1'b0;
    stop_n   = 1'b0;
    for (int k = 0; k < STEP_PAGES; k++) begin
      q  = p_q + PTR_W'(k);
      bi = q[BIT_W-1:0];
      if (alive && (({1'b0, p_q[BIT_W-1:0]} + (BIT_W+1)'(k)) < (BIT_W+1)'(WORD_BITS))
          && q < e_q) begin
        case (op_q)
          OP_SCAN: begin
            if (!w_n[bi]) begin
              if (run_n == '0) base_n = q[PAGE_W-1:0];
              run_n = run_n + CNT_W'(1);
              if (run_n == n_q) begin
                found_n = 1'b1;
                alive   = 1'b0;
              end
            end else begin
              run_n = '0;
            end
            p_n = q + PTR_W'(1);
          end
          OP_FREE: begin
            if (q >= PTR_W'(lim_q)) begin
              status_n = ST_RANGE;
              stop_n   = 1'b1;
              alive    = 1'b0;
            end else if (!w_n[bi]) begin
              status_n = ST_DOUBLE;
              stop_n   = 1'b1;
              alive    = 1'b0;
            end else begin
              w_n[bi] = 1'b0;
              inc     = inc + STEP_W'(1);
              p_n     = q + PTR_W'(1);
            end
          end
          OP_SETFREE: begin
            if (w_n[bi]) begin
              w_n[bi] = 1'b0;
              inc     = inc + STEP_W'(1);
            end
            p_n = q + PTR_W'(1);
          end
          OP_RESERVE: begin
            if (!w_n[bi]) begin
              w_n[bi] = 1'b1;
              dec     = dec + STEP_W'(1);
            end
            p_n = q + PTR_W'(1);
          end
          default: alive = 1'b0;
        endcase
      end else begin
        alive = 1'b0;
      end
    end
    if (op_q == OP_SCAN && !found_n && p_n >= e_q) status_n = ST_NORUN;
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_q     <= OP_NONE;
      status_q <= ST_OK;
      empty_q  <= 1'b0;
      cnt_q    <= '0;
      clr_q    <= '0;
      found_q  <= '0;
    end else begin
      if (cmd_i.accept) begin
        found_q <= '0;
        if (mode_i <= MODE_RESERVE && page_count_i == '0) begin
          op_q     <= OP_NONE;
          status_q <= ST_ZERO;
          empty_q  <= 1'b1;
        end else begin
          case (mode_i) inside
            MODE_ALLOC, MODE_ALLOC_DMA: begin
              op_q     <= OP_SCAN;
              empty_q  <= (lim_sel == '0);
              status_q <= (lim_sel == '0) ? ST_NORUN : ST_OK;
            end
            MODE_FREE: begin
              op_q     <= OP_FREE;
              empty_q  <= 1'b0;
              status_q <= ST_OK;
            end
            MODE_MARK_FREE, MODE_RESERVE: begin
              op_q     <= (mode_i == MODE_MARK_FREE) ? OP_SETFREE : OP_RESERVE;
              empty_q  <= (PTR_W'(start_page_i) >= end_clip);
              status_q <= ST_OK;
            end
            default: begin
              op_q     <= OP_NONE;
              empty_q  <= 1'b1;
              status_q <= ST_OK;
            end
          endcase
        end
      end
      if (cmd_i.clr) clr_q <= clr_q + WADDR_W'(1);
      if (cmd_i.proc) begin
        status_q <= status_n;
        cnt_q    <= cnt_q + CNT_W'(inc) - CNT_W'(dec);
      end
      if (cmd_i.mark) begin
        op_q    <= OP_RESERVE;
        found_q <= base_q;
      end
    end
  end

  // walk payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      n_q   <= page_count_i;
      lim_q <= lim_sel;
      run_q <= '0;
      case (mode_i) inside
        MODE_ALLOC, MODE_ALLOC_DMA: begin
          p_q <= '0;
          e_q <= PTR_W'(lim_sel);
        end
        MODE_FREE: begin
          p_q <= PTR_W'(start_page_i);
          e_q <= end_sum;
        end
        default: begin
          p_q <= PTR_W'(start_page_i);
          e_q <= end_clip;
        end
      endcase
    end
    if (cmd_i.load) begin
      w_q  <= rdata;
      wa_q <= p_q[BIT_W+WADDR_W-1:BIT_W];
    end
    if (cmd_i.proc) begin
      w_q    <= w_n;
      p_q    <= p_n;
      run_q  <= run_n;
      base_q <= base_n;
    end
    if (cmd_i.mark) begin
      p_q <= PTR_W'(base_q);
      e_q <= PTR_W'(base_q) + PTR_W'(n_q);
    end
  end

  // map RAM port
  always_comb begin
    if (cmd_i.clr)     ram_addr = clr_q;
    else if (cmd_i.rd) ram_addr = p_q[BIT_W+WADDR_W-1:BIT_W];
    else               ram_addr = wa_q;
  end

  bpfa_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (MAP_WORDS)
  ) u_map (
    .clk_i   (clk_i),
    .we_i    (cmd_i.clr | cmd_i.wr),
    .addr_i  (ram_addr),
    .wdata_i (cmd_i.clr ? {WORD_BITS{1'b1}} : w_q),
    .rdata_o (rdata)
  );

  // status to controller
  always_comb begin
    stat_o.empty    = empty_q;
    stat_o.found    = found_n;
    stat_o.stop     = stop_n;
    stat_o.walk_end = (p_n >= e_q);
    stat_o.word_end = (p_n[BIT_W-1:0] == '0);
    stat_o.writes   = (op_q != OP_SCAN);
    stat_o.clr_last = (clr_q == {WADDR_W{1'b1}});
  end

  assign status_o     = status_q;
  assign found_page_o = found_q;
  assign free_count_o = cnt_q;

  `BPFA_ASSERT_ALWAYS(a_cnt_span, cnt_q <= PAGE_SPAN, "free count above page span")
  `BPFA_ASSERT(a_found_scan, cmd_i.proc && found_n |-> op_q == OP_SCAN, "hit outside scan")
  `BPFA_ASSERT(a_mark_ok, cmd_i.mark |=> status_q == ST_OK, "mark after failed scan")

endmodule

`default_nettype wire

>>> rtl/bpfa_ctrl.sv
// ----------------------------------------------------------------------------
// bpfa_ctrl
// Sequencer: map clearing pass, word read/step/write loop, mark, result strobe.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module bpfa_ctrl import bpfa_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  start_i,
  input  wire stat_t stat_i,
  output cmd_t       cmd_o,
  output logic       busy_o,
  output logic       done_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    busy_o  = 1'b1;
    done_o  = 1'b0;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.clr = 1'b1;
        if (stat_i.clr_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        busy_o = 1'b0;
        if (start_i) begin
          cmd_o.accept = 1'b1;
          state_d      = S_CHECK;
        end
      end
      S_CHECK: state_d = stat_i.empty ? S_DONE : S_READ;
      S_READ: begin
        cmd_o.rd = 1'b1;
        state_d  = S_LOAD;
      end
      S_LOAD: begin
        cmd_o.load = 1'b1;
        state_d    = S_PROC;
      end
      S_PROC: begin
        cmd_o.proc = 1'b1;
        if (stat_i.found)                          state_d = S_MARK;
        else if (stat_i.stop || stat_i.walk_end)   state_d = stat_i.writes ? S_WRITE_END : S_DONE;
        else if (stat_i.word_end)                  state_d = stat_i.writes ? S_WRITE : S_READ;
      end
      S_WRITE: begin
        cmd_o.wr = 1'b1;
        state_d  = S_READ;
      end
      S_WRITE_END: begin
        cmd_o.wr = 1'b1;
        state_d  = S_DONE;
      end
      S_MARK: begin
        cmd_o.mark = 1'b1;
        state_d    = S_READ;
      end
      S_DONE: begin
        done_o  = 1'b1;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  `BPFA_ASSERT(a_done_pulse, done_o |=> !done_o, "result strobe longer than one cycle")
  `BPFA_ASSERT(a_accept_busy, start_i && !busy_o |=> busy_o, "not busy after accept")
  `BPFA_ASSERT(a_no_write_idle, !busy_o |-> !(cmd_o.wr || cmd_o.clr), "map written while idle")

endmodule

`default_nettype wire

>>> rtl/bitmap_page_frame_allocator_unit.sv
// ----------------------------------------------------------------------------
// bitmap_page_frame_allocator_unit
// First-fit bitmap page frame allocator with APB configuration registers.
// ----------------------------------------------------------------------------
//  channel   | handshake                          | payload
//  request   | start / busy                       | mode_i, start_page_i, page_count_i
//  result    | done_o strobe, one cycle           | status_o, found_page_o, free_count_o
//  config    | psel, penable, pwrite, pready      | paddr, pwdata, prdata
//
//  After reset the map is filled with ones, one word per cycle, all 1024 words, busy.
//  One request at a time. A writing walk takes each 64-page map word through
//  read, load, up to eight steps of up to eight pages, write back; a scan skips
//  the write back. The map RAM has a single port. Allocation scans, then marks.
//  A request with nothing to walk skips to done. Results cannot be stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module bitmap_page_frame_allocator_unit import bpfa_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  start,
  output logic                       busy,
  input  wire logic [2:0]            mode_i,
  input  wire logic [PAGE_W-1:0]     start_page_i,
  input  wire logic [CNT_W-1:0]      page_count_i,
  output logic                       done_o,
  output logic [2:0]                 status_o,
  output logic [PAGE_W-1:0]          found_page_o,
  output logic [CNT_W-1:0]           free_count_o,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [APB_ADDR_W-1:0] paddr,
  input  wire logic [APB_DATA_W-1:0] pwdata,
  output logic      [APB_DATA_W-1:0] prdata,
  output logic                       pready
);

  logic [CNT_W-1:0] total_pages_q, dma_limit_q;
  cmd_t             cmd;
  stat_t            stat;

  assign pready = 1'b1;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_pages_q <= PAGE_SPAN;
      dma_limit_q   <= PAGE_SPAN;
    end else if (psel && penable && pwrite && pready) begin
      unique case (paddr[2])
        REG_TOTAL_PAGES: total_pages_q <= pwdata[CNT_W-1:0];
        REG_DMA_LIMIT:   dma_limit_q   <= pwdata[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    unique case (paddr[2])
      REG_TOTAL_PAGES: prdata = APB_DATA_W'(total_pages_q);
      REG_DMA_LIMIT:   prdata = APB_DATA_W'(dma_limit_q);
      default:         prdata = '0;
    endcase
  end

  bpfa_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .stat_i  (stat),
    .cmd_o   (cmd),
    .busy_o  (busy),
    .done_o  (done_o)
  );

  bpfa_datapath u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .mode_i        (mode_i),
    .start_page_i  (start_page_i),
    .page_count_i  (page_count_i),
    .total_pages_i (total_pages_q),
    .dma_limit_i   (dma_limit_q),
    .status_o      (status_o),
    .found_page_o  (found_page_o),
    .free_count_o  (free_count_o)
  );

endmodule

`default_nettype wire
